@@ design/tli_pkg.sv @@
// Shared constants and codes for the text line index table.
package tli_pkg;

  localparam int unsigned TLI_MAX_LINES = 1024;
  localparam int unsigned TLI_POS_BITS  = 20;

  typedef enum logic [1:0] {
    MODE_CHAR = 2'd0,
    MODE_NL   = 2'd1,
    MODE_DEL  = 2'd2,
    MODE_NONE = 2'd3
  } tli_mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_POS  = 2'd1,
    ST_FULL     = 2'd2,
    ST_PAST_END = 2'd3
  } tli_status_e;

endpackage

@@ design/tli_engine.sv @@
// Edit sequencer and line table memory: search, merge and offset sweep.
module tli_engine import tli_pkg::*; #(
  parameter int unsigned MAX_LINES = TLI_MAX_LINES,
  parameter int unsigned POS_BITS  = TLI_POS_BITS,
  localparam int unsigned IDXW = $clog2(MAX_LINES),
  localparam int unsigned CNTW = $clog2(MAX_LINES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [POS_BITS-1:0] pos_i,
  input  logic [POS_BITS-1:0] cnt_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic [IDXW-1:0]     first_line_o,
  output logic [IDXW-1:0]     lines_changed_o,
  output logic [POS_BITS-1:0] line_start_o,
  output logic [POS_BITS-1:0] line_length_o,
  output logic [CNTW-1:0]     line_total_o,
  output logic [1:0]          status_o
);

  typedef enum logic [10:0] {
    S_INIT  = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_SRD   = 11'b000_0000_0100,
    S_SCMP  = 11'b000_0000_1000,
    S_MRG   = 11'b000_0001_0000,
    S_MWAIT = 11'b000_0010_0000,
    S_WRD   = 11'b000_0100_0000,
    S_WWR   = 11'b000_1000_0000,
    S_FIN1  = 11'b001_0000_0000,
    S_FIN2  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  localparam logic [POS_BITS-1:0] PosMax = {POS_BITS{1'b1}};

  state_e state_q, state_d;

  logic [2*POS_BITS-1:0] mem_q [MAX_LINES];
  logic [2*POS_BITS-1:0] rdata_q;
  logic                  rd_en, we;
  logic [IDXW-1:0]       raddr, waddr;
  logic [2*POS_BITS-1:0] wdata;

  logic [1:0]          mode_q;
  logic [POS_BITS-1:0] pos_q, cnt_q, end_q, st_q, len_q, curlen_q, left_q;
  logic [CNTW-1:0]     total_q, lo_q, hip1_q, mid_q, src_q, last_q;
  logic [IDXW-1:0]     line_q, merged_q;
  logic                force_q;
  logic [1:0]          status_q;

  logic [CNTW:0]       mid_sum;
  logic [CNTW-1:0]     mid, nxt, dst;
  logic [POS_BITS-1:0] r_start, r_len, room, delta;
  logic [POS_BITS:0]   del_end;
  logic [1:0]          chk;
  logic                can_merge;

  assign r_start   = rdata_q[2*POS_BITS-1:POS_BITS];
  assign r_len     = rdata_q[POS_BITS-1:0];
  assign mid_sum   = ({1'b0, lo_q} + {1'b0, hip1_q} - (CNTW+1)'(1)) >> 1;
  assign mid       = mid_sum[CNTW-1:0];
  assign nxt       = CNTW'(line_q) + CNTW'(1) + CNTW'(merged_q);
  assign room      = st_q + curlen_q - pos_q;
  assign can_merge = (left_q > room) && (nxt < total_q);
  assign delta     = (mode_q == MODE_DEL) ? (~cnt_q + POS_BITS'(1)) : POS_BITS'(1);
  assign del_end   = {1'b0, pos_i} + {1'b0, cnt_i};

  always_comb begin
    case (mode_q)
      MODE_NL:  dst = src_q + CNTW'(1);
      MODE_DEL: dst = src_q - CNTW'(merged_q);
      default:  dst = src_q;
    endcase
  end

  // Fault check against the tracked text end and line count.
  always_comb begin
    if (mode_i == MODE_NONE || pos_i > end_q) begin
      chk = ST_BAD_POS;
    end else if (mode_i != MODE_DEL && (end_q == PosMax ||
                 (mode_i == MODE_NL && total_q >= CNTW'(MAX_LINES)))) begin
      chk = ST_FULL;
    end else if (mode_i == MODE_DEL && del_end > {1'b0, end_q}) begin
      chk = ST_PAST_END;
    end else begin
      chk = ST_OK;
    end
  end

  // Memory port control.
  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (state_q)
      S_INIT: begin
        we = 1'b1;
      end
      S_SRD: begin
        rd_en = 1'b1;
        raddr = (lo_q < hip1_q) ? mid[IDXW-1:0] : '0;
      end
      S_MRG: begin
        rd_en = can_merge;
        raddr = nxt[IDXW-1:0];
      end
      S_WRD: begin
        rd_en = 1'b1;
        raddr = src_q[IDXW-1:0];
      end
      S_WWR: begin
        we    = 1'b1;
        waddr = dst[IDXW-1:0];
        wdata = {r_start + delta, r_len};
      end
      S_FIN1: begin
        we = 1'b1;
        if (mode_q == MODE_NL) begin
          waddr = line_q + IDXW'(1);
          wdata = {st_q + curlen_q + POS_BITS'(1), len_q - curlen_q};
        end else begin
          waddr = line_q;
          wdata = {st_q, curlen_q};
        end
      end
      S_FIN2: begin
        we    = 1'b1;
        waddr = line_q;
        wdata = {st_q, curlen_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:  state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = (chk == ST_OK) ? S_SRD : S_DONE;
      S_SRD:   state_d = S_SCMP;
      S_SCMP: begin
        if (force_q || (r_start <= pos_q &&
            {1'b0, pos_q} <= {1'b0, r_start} + {1'b0, r_len})) begin
          case (mode_q)
            MODE_CHAR: state_d = (mid + CNTW'(1) < total_q) ? S_WRD : S_FIN1;
            MODE_NL:   state_d = (mid + CNTW'(1) < total_q) ? S_WRD : S_FIN1;
            default:   state_d = S_MRG;
          endcase
        end else begin
          state_d = S_SRD;
        end
      end
      S_MRG: begin
        if (left_q > room && can_merge) state_d = S_MWAIT;
        else state_d = (nxt < total_q) ? S_WRD : S_FIN1;
      end
      S_MWAIT: state_d = S_MRG;
      S_WRD:   state_d = S_WWR;
      S_WWR:   state_d = (src_q == last_q) ? S_FIN1 : S_WRD;
      S_FIN1:  state_d = (mode_q == MODE_NL) ? S_FIN2 : S_DONE;
      S_FIN2:  state_d = S_DONE;
      S_DONE:  if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      total_q <= CNTW'(1);
      end_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN1) begin
        case (mode_q)
          MODE_CHAR: end_q <= end_q + POS_BITS'(1);
          MODE_NL: begin
            end_q   <= end_q + POS_BITS'(1);
            total_q <= total_q + CNTW'(1);
          end
          default: begin
            end_q   <= end_q - cnt_q;
            total_q <= total_q - CNTW'(merged_q);
          end
        endcase
      end
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        mode_q   <= mode_i;
        pos_q    <= pos_i;
        cnt_q    <= cnt_i;
        status_q <= chk;
        lo_q     <= '0;
        hip1_q   <= total_q;
        line_q   <= '0;
        merged_q <= '0;
        st_q     <= '0;
        curlen_q <= '0;
      end
      S_SRD: begin
        mid_q   <= mid;
        force_q <= !(lo_q < hip1_q);
      end
      S_SCMP: begin
        if (force_q || (r_start <= pos_q &&
            {1'b0, pos_q} <= {1'b0, r_start} + {1'b0, r_len})) begin
          line_q <= force_q ? '0 : mid_q[IDXW-1:0];
          st_q   <= r_start;
          len_q  <= r_len;
          case (mode_q)
            MODE_CHAR: begin
              curlen_q <= r_len + POS_BITS'(1);
              src_q    <= mid_q + CNTW'(1);
              last_q   <= total_q - CNTW'(1);
            end
            MODE_NL: begin
              curlen_q <= pos_q - r_start;
              merged_q <= IDXW'(1);
              src_q    <= total_q - CNTW'(1);
              last_q   <= mid_q + CNTW'(1);
            end
            default: begin
              curlen_q <= r_len;
              left_q   <= cnt_q;
            end
          endcase
        end else if (r_start > pos_q) begin
          hip1_q <= mid_q;
        end else begin
          lo_q <= mid_q + CNTW'(1);
        end
      end
      S_MRG: begin
        if (left_q <= room) begin
          curlen_q <= curlen_q - left_q;
          left_q   <= '0;
        end else begin
          curlen_q <= pos_q - st_q;
          left_q   <= left_q - room - POS_BITS'(1);
        end
        if (!(left_q > room && can_merge)) begin
          src_q  <= nxt;
          last_q <= total_q - CNTW'(1);
        end
      end
      S_MWAIT: begin
        curlen_q <= curlen_q + r_len;
        merged_q <= merged_q + IDXW'(1);
      end
      S_WWR: begin
        if (src_q != last_q) begin
          src_q <= (mode_q == MODE_NL) ? src_q - CNTW'(1) : src_q + CNTW'(1);
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign res_valid_o     = (state_q == S_DONE);
  assign first_line_o    = line_q;
  assign lines_changed_o = merged_q;
  assign line_start_o    = st_q;
  assign line_length_o   = curlen_q;
  assign line_total_o    = total_q;
  assign status_o        = status_q;

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q >= CNTW'(1) && total_q <= CNTW'(MAX_LINES))
    else $error("line count out of range");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !we)
    else $error("table write while idle");

  a_total_on_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != $past(total_q)) |-> $past(state_q == S_FIN1))
    else $error("line count moved outside commit");

  a_fault_no_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && chk != ST_OK) |=> state_q == S_DONE)
    else $error("faulted request entered edit path");

endmodule

@@ design/text_line_index_table.sv @@
// Top level of the text line index table: stream ports and result register.
//
// Line index for a text buffer under edit. Each request inserts a character,
// inserts a newline (splitting a line) or removes a run of characters, and
// yields exactly one result: the edited line, lines added or merged away, its
// start and length, and the line count, or a fault status with the table
// untouched. Line entries {start, length} live in one synchronous memory with
// a registered read port; a sequencer binary-searches it, then sweeps every
// later entry with a read and a write, plus a merge read per merged line on a
// removal and a commit step (two writes for a newline). After reset the
// sequencer seeds entry 0 before the first request is taken. A finished
// result waits in an output register, so the next request is taken while it
// is still pending downstream.
module text_line_index_table import tli_pkg::*; #(
  parameter int unsigned MAX_LINES = TLI_MAX_LINES,
  parameter int unsigned POS_BITS  = TLI_POS_BITS,
  localparam int unsigned IDXW  = $clog2(MAX_LINES),
  localparam int unsigned CNTW  = $clog2(MAX_LINES + 1),
  localparam int unsigned IN_B  = 2 + 2 * POS_BITS,
  localparam int unsigned IN_W  = ((IN_B + 7) / 8) * 8,
  localparam int unsigned OUT_B = 2 * IDXW + 2 * POS_BITS + CNTW + 2,
  localparam int unsigned OUT_W = ((OUT_B + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // mode, pos, del_count
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // first_line, lines_changed,
                                           // line_start, line_length,
                                           // line_total, status
);

  logic                res_valid, res_ready;
  logic [IDXW-1:0]     first_line, lines_changed;
  logic [POS_BITS-1:0] line_start, line_length;
  logic [CNTW-1:0]     line_total;
  logic [1:0]          status;
  logic                out_valid_q;
  logic [OUT_B-1:0]    out_data_q;

  tli_engine #(
    .MAX_LINES (MAX_LINES),
    .POS_BITS  (POS_BITS)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .mode_i          (s_axis_tdata[1:0]),
    .pos_i           (s_axis_tdata[2 +: POS_BITS]),
    .cnt_i           (s_axis_tdata[2 + POS_BITS +: POS_BITS]),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .first_line_o    (first_line),
    .lines_changed_o (lines_changed),
    .line_start_o    (line_start),
    .line_length_o   (line_length),
    .line_total_o    (line_total),
    .status_o        (status)
  );

  // Load the result register whenever it is empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= {status, line_total, line_length, line_start,
                     lines_changed, first_line};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_data_q);

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the text line index table stream block.
`timescale 1ns / 100ps

module testbench;
  import tli_pkg::*;

  localparam int unsigned POS_MAX  = (1 << TLI_POS_BITS) - 1;
  localparam int unsigned STALL_LIMIT = 60000;

  typedef struct packed {
    logic [19:0] del_count;
    logic [19:0] pos;
    logic [1:0]  mode;
  } edit_t;

  typedef struct packed {
    tli_status_e status;
    logic [10:0] line_total;
    logic [19:0] line_length;
    logic [19:0] line_start;
    logic [9:0]  lines_changed;
    logic [9:0]  first_line;
  } line_info_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // mode, pos, del_count
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // first_line, lines_changed, line_start,
                                    // line_length, line_total, status

  text_line_index_table dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Own copy of the line table, advanced at each accepted request.
  logic [19:0] start_q [TLI_MAX_LINES];
  logic [19:0] len_q   [TLI_MAX_LINES];
  int unsigned lines_q = 1;

  edit_t      edit_fifo [$];
  line_info_t info_fifo [$];
  int unsigned send_idle = 0, recv_idle = 0;
  int unsigned edits_pushed = 0, edits_taken = 0;
  int unsigned errors = 0, quiet_cycles = 0;

  function automatic int unsigned text_end();
    return start_q[lines_q-1] + len_q[lines_q-1];
  endfunction

  function automatic int unsigned find_line(int unsigned p);
    int lo, hi, mid;
    lo = 0;
    hi = int'(lines_q) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (start_q[mid] > p) hi = mid - 1;
      else if (p > start_q[mid] + len_q[mid]) lo = mid + 1;
      else return mid;
    end
    return 0;
  endfunction

  // Apply one edit to the line table and queue the line info it reports.
  function automatic void apply_edit(edit_t r);
    int unsigned e, p, c, ln, i, left, lend, room, d, shift, merged;
    line_info_t x;
    x = '0;
    x.status = ST_OK;
    e = text_end();
    p = r.pos;
    c = r.del_count;
    merged = 0;
    if (r.mode == MODE_NONE || p > e) begin
      x.status = ST_BAD_POS;
    end else if (r.mode != MODE_DEL &&
                 (e == POS_MAX || (r.mode == MODE_NL && lines_q >= TLI_MAX_LINES))) begin
      x.status = ST_FULL;
    end else if (r.mode == MODE_DEL && p + c > e) begin
      x.status = ST_PAST_END;
    end else begin
      ln = find_line(p);
      if (r.mode == MODE_CHAR) begin
        len_q[ln] += 1;
        for (i = ln + 1; i < lines_q; i++) start_q[i] += 1;
      end else if (r.mode == MODE_NL) begin
        shift = p - start_q[ln];
        for (i = lines_q; i > ln + 1; i--) begin
          start_q[i] = 20'(start_q[i-1] + 1);
          len_q[i]   = len_q[i-1];
        end
        start_q[ln+1] = 20'(p + 1);
        len_q[ln+1]   = 20'(len_q[ln] - shift);
        len_q[ln]     = 20'(shift);
        lines_q++;
        merged = 1;
      end else begin
        left = c;
        while (left > 0) begin
          lend = start_q[ln] + len_q[ln];
          if (lend == p) begin
            if (ln + 1 >= lines_q) break;
            // drop the line end: pull the next line into this one
            len_q[ln] += len_q[ln+1];
            for (i = ln + 1; i + 1 < lines_q; i++) begin
              start_q[i] = start_q[i+1];
              len_q[i]   = len_q[i+1];
            end
            lines_q--;
            merged++;
            left--;
          end else begin
            room = lend - p;
            d = room < left ? room : left;
            len_q[ln] -= 20'(d);
            left -= d;
          end
        end
        for (i = ln + 1; i < lines_q; i++) start_q[i] -= 20'(c);
      end
      x.first_line    = 10'(ln);
      x.lines_changed = 10'(merged);
      x.line_start    = start_q[ln];
      x.line_length   = len_q[ln];
    end
    x.line_total = 11'(lines_q);
    info_fifo.push_back(x);
  endfunction

  // Request driver: hold the request until taken, then advance or idle.
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (s_axis_tvalid) begin
        apply_edit(edit_t'(s_axis_tdata[41:0]));
        edits_taken++;
      end
      if (edit_fifo.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tdata  <= {6'd0, edit_fifo.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each taken result with the oldest expectation.
  always @(posedge clk_i) begin
    line_info_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = line_info_t'(m_axis_tdata[72:0]);
        if (info_fifo.size() == 0) begin
          errors++;
          $display("%0t unexpected result %h", $realtime, got);
        end else begin
          want = info_fifo.pop_front();
          if (got.first_line != want.first_line || got.lines_changed != want.lines_changed ||
              got.line_start != want.line_start || got.line_length != want.line_length ||
              got.line_total != want.line_total || got.status != want.status) begin
            errors++;
            $display("%0t mismatch expected line %0d chg %0d start %0d len %0d total %0d st %0d",
                     $realtime, want.first_line, want.lines_changed, want.line_start,
                     want.line_length, want.line_total, want.status);
            $display("%0t            actual line %0d chg %0d start %0d len %0d total %0d st %0d",
                     $realtime, got.first_line, got.lines_changed, got.line_start,
                     got.line_length, got.line_total, got.status);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: count cycles in which neither side moves a request or result.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("text_line_index_table verification failed");
      $finish;
    end
  end

  task automatic push_edit(logic [1:0] m, int unsigned p, int unsigned c);
    edit_t r;
    r.mode = m;
    r.pos = 20'(p);
    r.del_count = 20'(c);
    edit_fifo.push_back(r);
    edits_pushed++;
  endtask

  // Hold until every pushed request has been taken and predicted.
  task automatic settle();
    while (edits_taken != edits_pushed) @(posedge clk_i);
  endtask

  task automatic random_edits(int unsigned n);
    int unsigned e, k, p;
    repeat (n) begin
      while (edit_fifo.size() > 1) @(posedge clk_i);
      e = text_end();
      p = $urandom_range(e);
      k = $urandom_range(99);
      if (k < 40) push_edit(MODE_CHAR, p, $urandom);
      else if (k < 60) push_edit(MODE_NL, p, $urandom);
      else if (k < 82) push_edit(MODE_DEL, p, $urandom_range(e - p < 6 ? e - p : 6));
      else if (k < 86) push_edit(MODE_DEL, p, 0);
      else if (k < 91) push_edit(MODE_DEL, p, e - p + 1 + $urandom_range(3));
      else if (k < 96) push_edit(MODE_CHAR, e + 1 + $urandom_range(POS_MAX - e - 1), 0);
      else push_edit(MODE_NONE, $urandom_range(e), $urandom);
    end
  endtask

  initial begin
    start_q[0] = '0;
    len_q[0] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: faults and boundaries on an empty text, then splits and merges.
    send_idle = 18;
    recv_idle = 85;
    push_edit(MODE_DEL, 0, 0);
    push_edit(MODE_DEL, 0, 1);
    push_edit(MODE_DEL, 0, POS_MAX);
    push_edit(MODE_CHAR, POS_MAX, 0);
    push_edit(MODE_NL, 1, 0);
    push_edit(MODE_NONE, 0, 0);
    push_edit(MODE_CHAR, 0, POS_MAX);
    push_edit(MODE_CHAR, 1, 0);
    push_edit(MODE_NL, 0, 0);
    push_edit(MODE_NL, 3, 0);
    push_edit(MODE_CHAR, 2, 0);
    push_edit(MODE_NL, 2, 0);
    push_edit(MODE_CHAR, 6, 0);
    push_edit(MODE_DEL, 1, 3);
    push_edit(MODE_DEL, 0, 1);
    push_edit(MODE_DEL, 2, 0);
    push_edit(MODE_DEL, 0, 20'h55555);
    push_edit(MODE_NL, 20'hAAAAA, 20'h55555);
    push_edit(MODE_NONE, POS_MAX, POS_MAX);
    settle();
    random_edits(100);

    send_idle = 85;
    recv_idle = 18;
    random_edits(90);

    send_idle = 0;
    recv_idle = 0;
    random_edits(80);

    while (info_fifo.size() > 0 || edits_taken != edits_pushed) @(posedge clk_i);
    repeat (4400) @(posedge clk_i);
    if (errors == 0)
      $display("text_line_index_table verification clean");
    else
      $display("text_line_index_table verification failed");
    $finish;
  end

endmodule
